>>> hw/rtl/multipole_thin_kick_defines.svh
// ----------------------------------------------------------------------------
// multipole thin kick assertion macros
// shared concurrent assertion helpers, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef MULTIPOLE_THIN_KICK_DEFINES_SVH
`define MULTIPOLE_THIN_KICK_DEFINES_SVH

// condition implies consequence in the same cycle
`define MTK_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define MTK_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mtk_pkg.sv
// ----------------------------------------------------------------------------
// mtk_pkg
// types, constants and saturation helper of the multipole thin kick
// ----------------------------------------------------------------------------
package mtk_pkg;

    localparam int DATA_W = 48;
    localparam int SUM_W  = DATA_W + 2;
    localparam int PROD_W = 2 * DATA_W;
    localparam int HALF_W = DATA_W / 2;

    localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_KICK_LENGTH = 2'd0,
        CFG_INV_RHO     = 2'd1,
        CFG_TOP_ORDER   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ISSUE,
        ST_WAIT,
        ST_COMBINE,
        ST_BRK,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_XB,
        OP_YA,
        OP_YB,
        OP_XA,
        OP_HH,
        OP_HHX,
        OP_HD,
        OP_LBRK,
        OP_LBI,
        OP_LH,
        OP_LHX
    } op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] normal;
        logic signed [DATA_W-1:0] skew;
    } coef_pair_t;

    typedef struct packed {
        logic wr;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } sat_t;

    // sign extend one word to sum width
    function automatic logic signed [SUM_W-1:0] sx(input logic signed [DATA_W-1:0] v);
        return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // saturate an exact sum of up to three words
    function automatic sat_t clip_sum(input logic signed [SUM_W-1:0] v);
        sat_t r;
        r.sat = 1'b0;
        if (v > sx(WORD_MAX)) begin
            r.value = WORD_MAX;
            r.sat   = 1'b1;
        end else if (v < sx(WORD_MIN)) begin
            r.value = WORD_MIN;
            r.sat   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/multipole_thin_kick.sv
// a kick runs from input transfer through ring alignment, n Horner orders and the kick
//   terms to result valid, n = clamped top_order, plus any wait for the output register
// throughput: one kick at a time, set by the shared multi-cycle multiplier unit
//   (each 48x48 product is an issue plus a wait for done, 4 per order, 7 for the kick)
// the coefficient ring rotates TABLE_DEPTH places per kick and ends where it began
// reset: synchronous active-low aresetn clears control, config and output valid;
//   the coefficient table is not cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
// multipole_thin_kick
// thin-lens multipole kick with a rotating coefficient ring and shared multiplier
// ----------------------------------------------------------------------------
module multipole_thin_kick #(
    parameter int TABLE_DEPTH = 16,
    parameter int FRAC_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [mtk_pkg::DATA_W-1:0]        cfg_data,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [3:0]                        s_coeff_index,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_coeff_normal,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_coeff_skew,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_pos_x,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_mom_x,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_pos_y,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_mom_y,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_energy_dev,
    input  logic signed [mtk_pkg::DATA_W-1:0] s_path_len,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mtk_pkg::DATA_W-1:0] m_out_pos_x,
    output logic signed [mtk_pkg::DATA_W-1:0] m_out_mom_x,
    output logic signed [mtk_pkg::DATA_W-1:0] m_out_pos_y,
    output logic signed [mtk_pkg::DATA_W-1:0] m_out_mom_y,
    output logic signed [mtk_pkg::DATA_W-1:0] m_out_energy_dev,
    output logic signed [mtk_pkg::DATA_W-1:0] m_out_path_len,
    output logic                              m_overflow
);
    import mtk_pkg::*;

    `include "multipole_thin_kick_defines.svh"

    localparam int IDXW = $clog2(TABLE_DEPTH);

    // configuration registers
    logic signed [DATA_W-1:0] kick_length_reg;
    logic signed [DATA_W-1:0] inv_rho_reg;
    logic [3:0]               top_order_reg;

    // sequencer
    state_t    state_reg, state_next;
    op_t       op_reg, op_next;
    logic [IDXW-1:0] align_reg;
    logic [IDXW-1:0] steps_reg;
    logic      mul_start;
    logic      ring_shift;
    logic      out_load;

    // particle and work registers
    logic signed [DATA_W-1:0] x_reg, px_reg, y_reg, py_reg, dl_reg, ct_reg;
    logic signed [DATA_W-1:0] br_reg, bi_reg, brk_reg;
    logic signed [DATA_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic                     sat_reg;

    // output register
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] o_x_reg, o_px_reg, o_y_reg, o_py_reg, o_dl_reg, o_ct_reg;
    logic                     o_ovf_reg;

    logic s_xfer;
    logic load_xfer;
    logic kick_xfer;
    logic [31:0]     order_w;
    logic [IDXW-1:0] n_clamp;

    // coefficient ring
    coef_pair_t cell_q [TABLE_DEPTH];
    coef_pair_t wr_pair;
    coef_pair_t head, after_head;
    logic       idx_ok;

    // multiplier
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic  mul_done;
    sat_t  mul_res;

    // combine results
    sat_t nr_s, ni_s, brk_s, kpx_s, kpy_s, kct_s;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign load_xfer = s_xfer && !s_action;
    assign kick_xfer = s_xfer && s_action;

    // clamp the Horner start to the last table entry
    assign order_w = 32'(top_order_reg);
    assign n_clamp = (order_w > 32'(TABLE_DEPTH - 1)) ? IDXW'(TABLE_DEPTH - 1)
                                                      : IDXW'(order_w);

    // config write transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_length_reg <= '0;
            inv_rho_reg     <= '0;
            top_order_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KICK_LENGTH: kick_length_reg <= cfg_data;
                CFG_INV_RHO:     inv_rho_reg     <= cfg_data;
                CFG_TOP_ORDER:   top_order_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ring of cells: at rest cell j holds entry j, head is the last cell;
    // a shift moves every pair one cell up so the head steps one entry down
    assign idx_ok          = (32'(s_coeff_index) < TABLE_DEPTH);
    assign wr_pair.normal  = s_coeff_normal;
    assign wr_pair.skew    = s_coeff_skew;
    assign head            = cell_q[TABLE_DEPTH-1];
    assign after_head      = cell_q[TABLE_DEPTH-2];

    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
        cell_ctl_t ctl;
        assign ctl.wr    = load_xfer && idx_ok && (IDXW'(s_coeff_index) == IDXW'(j));
        assign ctl.shift = ring_shift;
        mtk_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .wr_data   (wr_pair),
            .prev_data (cell_q[(j + TABLE_DEPTH - 1) % TABLE_DEPTH]),
            .data      (cell_q[j])
        );
    end

    // operand select per multiply
    always_comb begin
        case (op_reg)
            OP_XB:   begin mul_a = x_reg;           mul_b = br_reg; end
            OP_YA:   begin mul_a = y_reg;           mul_b = bi_reg; end
            OP_YB:   begin mul_a = y_reg;           mul_b = br_reg; end
            OP_XA:   begin mul_a = x_reg;           mul_b = bi_reg; end
            OP_HH:   begin mul_a = inv_rho_reg;     mul_b = inv_rho_reg; end
            OP_HHX:  begin mul_a = pa_reg;          mul_b = x_reg; end
            OP_HD:   begin mul_a = inv_rho_reg;     mul_b = dl_reg; end
            OP_LBRK: begin mul_a = kick_length_reg; mul_b = brk_reg; end
            OP_LBI:  begin mul_a = kick_length_reg; mul_b = bi_reg; end
            OP_LH:   begin mul_a = kick_length_reg; mul_b = inv_rho_reg; end
            OP_LHX:  begin mul_a = pc_reg;          mul_b = x_reg; end
            default: begin mul_a = x_reg;           mul_b = br_reg; end
        endcase
    end

    mtk_fmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // one Horner order: B' = (x + iy) * B + next coefficient
    assign nr_s  = clip_sum(sx(pa_reg) - sx(pb_reg) + sx(after_head.normal));
    assign ni_s  = clip_sum(sx(pc_reg) + sx(pd_reg) + sx(after_head.skew));
    // bend bracket By + h*h*x - h*delta
    assign brk_s = clip_sum(sx(br_reg) + sx(pb_reg) - sx(pc_reg));
    // final kicks
    assign kpx_s = clip_sum(sx(px_reg) - sx(pa_reg));
    assign kpy_s = clip_sum(sx(py_reg) + sx(pb_reg));
    assign kct_s = clip_sum(sx(ct_reg) + sx(pd_reg));

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        mul_start  = 1'b0;
        ring_shift = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (kick_xfer) begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (align_reg != '0) begin
                    ring_shift = 1'b1;
                end else begin
                    state_next = ST_ISSUE;
                    op_next    = (steps_reg == '0) ? OP_HH : OP_XB;
                end
            end
            ST_ISSUE: begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_XB:   op_next = OP_YA;
                        OP_YA:   op_next = OP_YB;
                        OP_YB:   op_next = OP_XA;
                        OP_XA:   state_next = ST_COMBINE;
                        OP_HH:   op_next = OP_HHX;
                        OP_HHX:  op_next = OP_HD;
                        OP_HD:   state_next = ST_BRK;
                        OP_LBRK: op_next = OP_LBI;
                        OP_LBI:  op_next = OP_LH;
                        OP_LH:   op_next = OP_LHX;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_COMBINE: begin
                ring_shift = 1'b1;
                state_next = ST_ISSUE;
                op_next    = (steps_reg == IDXW'(1)) ? OP_HH : OP_XB;
            end
            ST_BRK: begin
                state_next = ST_ISSUE;
                op_next    = OP_LBRK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    ring_shift = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_XB;
            align_reg <= '0;
            steps_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (kick_xfer) begin
                align_reg <= IDXW'(TABLE_DEPTH - 1) - n_clamp;
                steps_reg <= n_clamp;
            end else if (state_reg == ST_ALIGN && align_reg != '0) begin
                align_reg <= align_reg - IDXW'(1);
            end else if (state_reg == ST_COMBINE) begin
                steps_reg <= steps_reg - IDXW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (kick_xfer) begin
            x_reg   <= s_pos_x;
            px_reg  <= s_mom_x;
            y_reg   <= s_pos_y;
            py_reg  <= s_mom_y;
            dl_reg  <= s_energy_dev;
            ct_reg  <= s_path_len;
            sat_reg <= 1'b0;
        end
        if (state_reg == ST_ALIGN && align_reg == '0) begin
            br_reg <= head.normal;
            bi_reg <= head.skew;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            if (mul_res.sat) begin
                sat_reg <= 1'b1;
            end
            case (op_reg)
                OP_XB, OP_HH, OP_LBRK: pa_reg <= mul_res.value;
                OP_YA, OP_HHX, OP_LBI: pb_reg <= mul_res.value;
                OP_YB, OP_HD, OP_LH:   pc_reg <= mul_res.value;
                default:               pd_reg <= mul_res.value;
            endcase
        end
        if (state_reg == ST_COMBINE) begin
            br_reg <= nr_s.value;
            bi_reg <= ni_s.value;
            if (nr_s.sat || ni_s.sat) begin
                sat_reg <= 1'b1;
            end
        end
        if (state_reg == ST_BRK) begin
            brk_reg <= brk_s.value;
            if (brk_s.sat) begin
                sat_reg <= 1'b1;
            end
        end
    end

    // output register, refilled only once the previous result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_x_reg   <= x_reg;
            o_px_reg  <= kpx_s.value;
            o_y_reg   <= y_reg;
            o_py_reg  <= kpy_s.value;
            o_dl_reg  <= dl_reg;
            o_ct_reg  <= kct_s.value;
            o_ovf_reg <= sat_reg || kpx_s.sat || kpy_s.sat || kct_s.sat;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_pos_x      = o_x_reg;
    assign m_out_mom_x      = o_px_reg;
    assign m_out_pos_y      = o_y_reg;
    assign m_out_mom_y      = o_py_reg;
    assign m_out_energy_dev = o_dl_reg;
    assign m_out_path_len   = o_ct_reg;
    assign m_overflow       = o_ovf_reg;

    // assertions
    `MTK_ASSERT_SAME(a_done_in_wait, mul_done, state_reg == ST_WAIT,
        "multiplier finished outside wait state")
    `MTK_ASSERT_SAME(a_combine_steps, state_reg == ST_COMBINE, steps_reg != '0,
        "horner combine with no order left")
    `MTK_ASSERT_NEXT(a_done_fills_out, out_load, m_valid_reg && state_reg == ST_IDLE,
        "result load did not present a transfer")
    `MTK_ASSERT_SAME(a_ring_idle, ring_shift,
        state_reg == ST_ALIGN || state_reg == ST_COMBINE || state_reg == ST_DONE,
        "coefficient ring rotated outside a kick")

endmodule

>>> hw/rtl/mtk_cell.sv
// ----------------------------------------------------------------------------
// mtk_cell
// one coefficient slot of the rotating table ring
// ----------------------------------------------------------------------------
module mtk_cell (
    input  logic                aclk,
    input  mtk_pkg::cell_ctl_t  ctl,
    input  mtk_pkg::coef_pair_t wr_data,
    input  mtk_pkg::coef_pair_t prev_data,
    output mtk_pkg::coef_pair_t data
);
    import mtk_pkg::*;

    coef_pair_t data_reg;

    // load writes the slot, otherwise take the neighbor's pair on a shift
    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            data_reg <= wr_data;
        end else if (ctl.shift) begin
            data_reg <= prev_data;
        end
    end

    assign data = data_reg;

endmodule

>>> hw/rtl/mtk_fmul.sv
// ----------------------------------------------------------------------------
// mtk_fmul
// multi-cycle fixed-point multiply, rounded half away from zero, saturated
// ----------------------------------------------------------------------------
module mtk_fmul #(
    parameter int FRAC_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [mtk_pkg::DATA_W-1:0] op_a,
    input  logic signed [mtk_pkg::DATA_W-1:0] op_b,
    output logic                             done,
    output mtk_pkg::sat_t                    result
);
    import mtk_pkg::*;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [2:0]        STEP_LAST  = 3'd5;

    logic              busy_reg;
    logic [2:0]        step_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] ma_reg;
    logic [DATA_W-1:0] mb_reg;
    logic [DATA_W-1:0] pp_reg;
    logic [1:0]        sh_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              done_reg;
    sat_t              result_reg;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [DATA_W-1:0] pp_next;
    logic [1:0]        sh_next;
    logic [PROD_W-1:0] pp_shifted;
    logic [PROD_W-1:0] rounded;
    logic [PROD_W-1:0] quot;
    logic              sat_flag;

    // partial product select: low*low, low*high, high*low, high*high
    always_comb begin
        case (step_reg[1:0])
            2'd0: begin
                a_half = ma_reg[HALF_W-1:0];
                b_half = mb_reg[HALF_W-1:0];
                sh_next = 2'd0;
            end
            2'd1: begin
                a_half = ma_reg[HALF_W-1:0];
                b_half = mb_reg[DATA_W-1:HALF_W];
                sh_next = 2'd1;
            end
            2'd2: begin
                a_half = ma_reg[DATA_W-1:HALF_W];
                b_half = mb_reg[HALF_W-1:0];
                sh_next = 2'd1;
            end
            default: begin
                a_half = ma_reg[DATA_W-1:HALF_W];
                b_half = mb_reg[DATA_W-1:HALF_W];
                sh_next = 2'd2;
            end
        endcase
        pp_next = DATA_W'(a_half) * DATA_W'(b_half);
        case (sh_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            default: pp_shifted = PROD_W'(pp_reg) << DATA_W;
        endcase
        rounded  = acc_reg + ROUND_HALF;
        quot     = rounded >> FRAC_BITS;
        sat_flag = neg_reg ? (quot > PROD_W'(WORD_MIN)) : (quot > PROD_W'(WORD_MAX));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            ma_reg  <= op_a[DATA_W-1] ? DATA_W'(-op_a) : op_a;
            mb_reg  <= op_b[DATA_W-1] ? DATA_W'(-op_b) : op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg <= 3'd3) begin
                pp_reg <= pp_next;
                sh_reg <= sh_next;
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                acc_reg <= acc_reg + pp_shifted;
            end
            if (step_reg == STEP_LAST) begin
                result_reg.sat <= sat_flag;
                if (sat_flag) begin
                    result_reg.value <= neg_reg ? WORD_MIN : WORD_MAX;
                end else begin
                    result_reg.value <= neg_reg ? DATA_W'(-quot[DATA_W-1:0])
                                                : quot[DATA_W-1:0];
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
